// ===== hdl/bc1_subblock_decode_core_defines.svh =====
// ----------------------------------------------------------------------------
// bc1 sub-block decoder assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef BC1_SUBBLOCK_DECODE_CORE_DEFINES_SVH
`define BC1_SUBBLOCK_DECODE_CORE_DEFINES_SVH

// same-cycle implication, quiet while reset is held
`define BC1SD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bc1sd check failed");

// next-cycle implication, quiet while reset is held
`define BC1SD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bc1sd check failed");

`endif

// ===== hdl/bc1sd_pkg.sv =====
// ----------------------------------------------------------------------------
// bc1sd_pkg
// Types and constants shared by the bc1 sub-block decoder stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bc1sd_pkg;

    localparam int CH_W    = 8;
    localparam int SUM_W   = 10;
    localparam int SEL_W   = 32;
    localparam int IDX_W   = 2;
    localparam int PIXNUM_W = 4;

    localparam logic [PIXNUM_W-1:0] PIX_LAST = 4'hF;

    localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [CH_W-1:0] ALPHA_CLEAR  = 8'h00;

    // palette index codes
    localparam logic [IDX_W-1:0] IDX_C0 = 2'd0;
    localparam logic [IDX_W-1:0] IDX_C1 = 2'd1;
    localparam logic [IDX_W-1:0] IDX_C2 = 2'd2;
    localparam logic [IDX_W-1:0] IDX_C3 = 2'd3;

    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
    } rgb_t;

    typedef struct packed {
        logic [SUM_W-1:0] r;
        logic [SUM_W-1:0] g;
        logic [SUM_W-1:0] b;
    } sum_t;

    // after endpoint widening
    typedef struct packed {
        rgb_t             c0;
        rgb_t             c1;
        logic             four_mode;
        logic [SEL_W-1:0] sel;
    } expand_t;

    // finished four-entry palette with its indices
    typedef struct packed {
        rgb_t             c0;
        rgb_t             c1;
        rgb_t             c2;
        rgb_t             c3;
        logic             transparent;
        logic [SEL_W-1:0] sel;
    } block_t;

endpackage

// ===== hdl/bc1sd_if.sv =====
// ----------------------------------------------------------------------------
// bc1sd channel interfaces
// Compressed block request channel and decoded pixel request channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bc1sd_block_if;
    logic        valid;
    logic        ready;
    logic [15:0] endpoint_a;
    logic [15:0] endpoint_b;
    logic [31:0] selector_bits;

    modport source (output valid, endpoint_a, endpoint_b, selector_bits, input ready);
    modport sink   (input valid, endpoint_a, endpoint_b, selector_bits, output ready);
endinterface

interface bc1sd_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [3:0] pixel_number;
    logic       last_pixel;

    modport source (output valid, red, green, blue, alpha, pixel_number, last_pixel,
                    input ready);
    modport sink   (input valid, red, green, blue, alpha, pixel_number, last_pixel,
                    output ready);
endinterface

// ===== hdl/bc1sd_expand.sv =====
// ----------------------------------------------------------------------------
// bc1sd_expand
// First stage: widens both RGB565 endpoints and picks the palette mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bc1sd_expand import bc1sd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [15:0]      endpoint_a,
    input  logic [15:0]      endpoint_b,
    input  logic [SEL_W-1:0] selector_bits,
    output logic             out_valid,
    input  logic             out_ready,
    output expand_t          out_data
);

    logic    valid_reg;
    expand_t data_reg;
    expand_t data_next;

    // plain shift, no bit replication
    function automatic rgb_t widen565(input logic [15:0] c);
        rgb_t w;
        w.r = {c[15:11], 3'b000};
        w.g = {c[10:5], 2'b00};
        w.b = {c[4:0], 3'b000};
        return w;
    endfunction

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        data_next.c0        = widen565(endpoint_a);
        data_next.c1        = widen565(endpoint_b);
        data_next.four_mode = endpoint_a > endpoint_b;
        data_next.sel       = selector_bits;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== hdl/bc1sd_blend.sv =====
// ----------------------------------------------------------------------------
// bc1sd_blend
// Two stages: weighted channel sums, then divide by three or two.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bc1sd_blend import bc1sd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  expand_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output block_t  out_data
);

    localparam int RECIP_W     = 10;
    localparam int RECIP_SHIFT = 11;
    localparam int PROD_W      = SUM_W + RECIP_W;
    // 683 / 2048 gives the exact floor of x / 3 for any x below 2048
    localparam logic [RECIP_W-1:0] RECIP3 = 10'd683;

    typedef struct packed {
        rgb_t             c0;
        rgb_t             c1;
        sum_t             s2;
        sum_t             s3;
        logic             four_mode;
        logic [SEL_W-1:0] sel;
    } blend_sum_t;

    logic       sum_valid_reg;
    blend_sum_t sum_reg;
    blend_sum_t sum_next;
    logic       tbl_valid_reg;
    block_t     tbl_reg;
    block_t     tbl_next;
    logic       s3_ready;

    function automatic logic [SUM_W-1:0] ext(input logic [CH_W-1:0] v);
        return {{(SUM_W-CH_W){1'b0}}, v};
    endfunction

    function automatic logic [CH_W-1:0] div3(input logic [SUM_W-1:0] x);
        logic [PROD_W-1:0] prod;
        prod = {{RECIP_W{1'b0}}, x} * {{SUM_W{1'b0}}, RECIP3};
        return prod[RECIP_SHIFT +: CH_W];
    endfunction

    function automatic logic [CH_W-1:0] half(input logic [SUM_W-1:0] x);
        return x[1 +: CH_W];
    endfunction

    assign s3_ready = !tbl_valid_reg || out_ready;
    assign in_ready = !sum_valid_reg || s3_ready;

    always_comb
    begin
        sum_next.c0        = in_data.c0;
        sum_next.c1        = in_data.c1;
        sum_next.four_mode = in_data.four_mode;
        sum_next.sel       = in_data.sel;
        // entry 3 is c0 + 2*c1 in both modes
        sum_next.s3.r = ext(in_data.c0.r) + (ext(in_data.c1.r) << 1);
        sum_next.s3.g = ext(in_data.c0.g) + (ext(in_data.c1.g) << 1);
        sum_next.s3.b = ext(in_data.c0.b) + (ext(in_data.c1.b) << 1);
        if (in_data.four_mode)
        begin
            sum_next.s2.r = (ext(in_data.c0.r) << 1) + ext(in_data.c1.r);
            sum_next.s2.g = (ext(in_data.c0.g) << 1) + ext(in_data.c1.g);
            sum_next.s2.b = (ext(in_data.c0.b) << 1) + ext(in_data.c1.b);
        end
        else
        begin
            sum_next.s2.r = ext(in_data.c0.r) + ext(in_data.c1.r);
            sum_next.s2.g = ext(in_data.c0.g) + ext(in_data.c1.g);
            sum_next.s2.b = ext(in_data.c0.b) + ext(in_data.c1.b);
        end
    end

    always_comb
    begin
        tbl_next.c0          = sum_reg.c0;
        tbl_next.c1          = sum_reg.c1;
        tbl_next.sel         = sum_reg.sel;
        tbl_next.transparent = !sum_reg.four_mode;
        tbl_next.c3.r        = div3(sum_reg.s3.r);
        tbl_next.c3.g        = div3(sum_reg.s3.g);
        tbl_next.c3.b        = div3(sum_reg.s3.b);
        if (sum_reg.four_mode)
        begin
            tbl_next.c2.r = div3(sum_reg.s2.r);
            tbl_next.c2.g = div3(sum_reg.s2.g);
            tbl_next.c2.b = div3(sum_reg.s2.b);
        end
        else
        begin
            tbl_next.c2.r = half(sum_reg.s2.r);
            tbl_next.c2.g = half(sum_reg.s2.g);
            tbl_next.c2.b = half(sum_reg.s2.b);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
            tbl_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                sum_valid_reg <= in_valid;
            end
            if (s3_ready)
            begin
                tbl_valid_reg <= sum_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sum_reg <= sum_next;
        end
        if (sum_valid_reg && s3_ready)
        begin
            tbl_reg <= tbl_next;
        end
    end

    assign out_valid = tbl_valid_reg;
    assign out_data  = tbl_reg;

endmodule

// ===== hdl/bc1sd_emit.sv =====
// ----------------------------------------------------------------------------
// bc1sd_emit
// Holds one palette and walks its sixteen indices into the pixel register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bc1sd_emit import bc1sd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                blk_valid,
    output logic                blk_ready,
    input  block_t              blk_data,
    output logic                pix_valid,
    input  logic                pix_ready,
    output logic [CH_W-1:0]     red,
    output logic [CH_W-1:0]     green,
    output logic [CH_W-1:0]     blue,
    output logic [CH_W-1:0]     alpha,
    output logic [PIXNUM_W-1:0] pixel_number,
    output logic                last_pixel
);

    logic                busy_reg;
    logic [PIXNUM_W-1:0] count_reg;
    block_t              tbl_reg;
    logic                out_valid_reg;
    logic [CH_W-1:0]     red_reg;
    logic [CH_W-1:0]     green_reg;
    logic [CH_W-1:0]     blue_reg;
    logic [CH_W-1:0]     alpha_reg;
    logic [PIXNUM_W-1:0] num_reg;
    logic                last_reg;

    logic                out_adv;
    logic                load_pix;
    logic                at_last;
    logic                blk_take;
    logic [IDX_W-1:0]    idx;
    rgb_t                pick;
    logic [CH_W-1:0]     pick_alpha;

    assign out_adv   = !out_valid_reg || pix_ready;
    assign load_pix  = busy_reg && out_adv;
    assign at_last   = count_reg == PIX_LAST;
    // a new palette loads in the same cycle the last pixel of the old one leaves
    assign blk_ready = !busy_reg || (load_pix && at_last);
    assign blk_take  = blk_valid && blk_ready;
    assign idx       = tbl_reg.sel[SEL_W-1 -: IDX_W];

    always_comb
    begin
        pick       = tbl_reg.c0;
        pick_alpha = ALPHA_OPAQUE;
        unique case (idx)
            IDX_C0: pick = tbl_reg.c0;
            IDX_C1: pick = tbl_reg.c1;
            IDX_C2: pick = tbl_reg.c2;
            IDX_C3:
            begin
                pick       = tbl_reg.c3;
                pick_alpha = tbl_reg.transparent ? ALPHA_CLEAR : ALPHA_OPAQUE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (blk_take)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (load_pix)
            begin
                busy_reg  <= !at_last;
                count_reg <= count_reg + 1'b1;
            end
            if (out_adv)
            begin
                out_valid_reg <= busy_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (blk_take)
        begin
            tbl_reg <= blk_data;
        end
        else if (load_pix)
        begin
            tbl_reg.sel <= tbl_reg.sel << IDX_W;
        end
        if (load_pix)
        begin
            red_reg   <= pick.r;
            green_reg <= pick.g;
            blue_reg  <= pick.b;
            alpha_reg <= pick_alpha;
            num_reg   <= count_reg;
            last_reg  <= at_last;
        end
    end

    assign pix_valid    = out_valid_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign alpha        = alpha_reg;
    assign pixel_number = num_reg;
    assign last_pixel   = last_reg;

endmodule

// ===== hdl/bc1_subblock_decode_core.sv =====
// ----------------------------------------------------------------------------
// bc1_subblock_decode_core
// path: an accepted block goes through the expand, sum and table registers,
//   then the emitter palette and pixel registers; throughput: one pixel per
//   cycle while ready, as the emitter walks the held palette's sixteen indices
// reset: rst_n clears all stage valid bits and the emitter counter at once
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bc1_subblock_decode_core import bc1sd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    bc1sd_block_if.sink          blocks,
    bc1sd_pixel_if.source        pixels
);

    logic    exp_valid;
    logic    exp_ready;
    expand_t exp_data;
    logic    tbl_valid;
    logic    tbl_ready;
    block_t  tbl_data;

    bc1sd_expand u_expand
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (blocks.valid),
        .in_ready      (blocks.ready),
        .endpoint_a    (blocks.endpoint_a),
        .endpoint_b    (blocks.endpoint_b),
        .selector_bits (blocks.selector_bits),
        .out_valid     (exp_valid),
        .out_ready     (exp_ready),
        .out_data      (exp_data)
    );

    bc1sd_blend u_blend
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (exp_valid),
        .in_ready  (exp_ready),
        .in_data   (exp_data),
        .out_valid (tbl_valid),
        .out_ready (tbl_ready),
        .out_data  (tbl_data)
    );

    bc1sd_emit u_emit
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .blk_valid    (tbl_valid),
        .blk_ready    (tbl_ready),
        .blk_data     (tbl_data),
        .pix_valid    (pixels.valid),
        .pix_ready    (pixels.ready),
        .red          (pixels.red),
        .green        (pixels.green),
        .blue         (pixels.blue),
        .alpha        (pixels.alpha),
        .pixel_number (pixels.pixel_number),
        .last_pixel   (pixels.last_pixel)
    );

endmodule

// ===== hdl/bc1sd_checker.sv =====
// ----------------------------------------------------------------------------
// bc1sd_checker
// Port-level checks on block and pixel requests, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bc1_subblock_decode_core_defines.svh"

module bc1sd_checker
(
    input logic           clk,
    input logic           rst_n,
    bc1sd_block_if.sink   blocks,
    bc1sd_pixel_if.source pixels
);

    logic       blk_acc;
    logic       pix_acc;
    logic       blk_done;
    logic [3:0] exp_num_reg;
    logic [2:0] open_reg;

    assign blk_acc  = blocks.valid && blocks.ready;
    assign pix_acc  = pixels.valid && pixels.ready;
    assign blk_done = pix_acc && pixels.last_pixel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_num_reg <= '0;
            open_reg    <= '0;
        end
        else
        begin
            if (pix_acc)
            begin
                exp_num_reg <= exp_num_reg + 1'b1;
            end
            open_reg <= open_reg + {2'b00, blk_acc} - {2'b00, blk_done};
        end
    end

    // pixels come out in raster order, sixteen per block
    `BC1SD_ASSERT_IMPLY(a_pix_order, clk, rst_n, pixels.valid,
        pixels.pixel_number == exp_num_reg)

    `BC1SD_ASSERT_IMPLY(a_last_mark, clk, rst_n, pixels.valid,
        pixels.last_pixel == (pixels.pixel_number == 4'hF))

    // no pixel without an accepted block, and the pipe holds at most five blocks
    `BC1SD_ASSERT_IMPLY(a_open_blocks, clk, rst_n, pixels.valid,
        (open_reg != 3'd0) && (open_reg <= 3'd5))

    `BC1SD_ASSERT_NEXT(a_pix_hold, clk, rst_n, pixels.valid && !pixels.ready,
        pixels.valid && $stable(pixels.red) && $stable(pixels.green) &&
        $stable(pixels.blue) && $stable(pixels.alpha) &&
        $stable(pixels.pixel_number) && $stable(pixels.last_pixel))

endmodule

bind bc1_subblock_decode_core bc1sd_checker u_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .blocks (blocks),
    .pixels (pixels)
);

// ===== dv/bc1sd_pixel_check.sv =====
// ----------------------------------------------------------------------------
// bc1sd_pixel_check
// Watches the block and pixel request channels of the bc1 sub-block decoder.
// It predicts the sixteen pixels of every accepted block and compares each
// accepted pixel, field by field, against the oldest pixel still owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bc1sd_pixel_check import bc1sd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    bc1sd_block_if      blocks,
    bc1sd_pixel_if      pixels,
    output int unsigned mismatches,
    output int unsigned pixels_owed,
    output int unsigned pixels_seen
);

    typedef struct packed {
        logic [CH_W-1:0]     red;
        logic [CH_W-1:0]     green;
        logic [CH_W-1:0]     blue;
        logic [CH_W-1:0]     alpha;
        logic [PIXNUM_W-1:0] pixel_number;
        logic                last_pixel;
    } pixel_t;

    pixel_t owed_pixels[$];

    // plain shift, no bit replication
    function automatic rgb_t expand_endpoint(input logic [15:0] c);
        return {c[15:11], 3'b000, c[10:5], 2'b00, c[4:0], 3'b000};
    endfunction

    function automatic logic [CH_W-1:0] mix_channel(input logic [CH_W-1:0] p, q,
                                                    input int wp, wq, dv);
        return CH_W'((wp * int'(p) + wq * int'(q)) / dv);
    endfunction

    function automatic rgb_t mix_colour(input rgb_t p, q, input int wp, wq, dv);
        rgb_t m;
        m.r = mix_channel(p.r, q.r, wp, wq, dv);
        m.g = mix_channel(p.g, q.g, wp, wq, dv);
        m.b = mix_channel(p.b, q.b, wp, wq, dv);
        return m;
    endfunction

    function automatic void decode_block(input logic [15:0] ea, eb,
                                         input logic [SEL_W-1:0] sel);
        rgb_t             palette [4];
        logic             four_colour;
        logic [IDX_W-1:0] idx;
        pixel_t           px;
        four_colour = (ea > eb);
        palette[IDX_C0] = expand_endpoint(ea);
        palette[IDX_C1] = expand_endpoint(eb);
        if (four_colour)
        begin
            palette[IDX_C2] = mix_colour(palette[IDX_C0], palette[IDX_C1], 2, 1, 3);
            palette[IDX_C3] = mix_colour(palette[IDX_C0], palette[IDX_C1], 1, 2, 3);
        end
        else
        begin
            palette[IDX_C2] = mix_colour(palette[IDX_C0], palette[IDX_C1], 1, 1, 2);
            palette[IDX_C3] = mix_colour(palette[IDX_C0], palette[IDX_C1], 1, 2, 3);
        end
        // pixel 0 takes the top index bits
        for (int i = 0; i < 16; i++)
        begin
            idx = sel[SEL_W-1-2*i -: IDX_W];
            px.red   = palette[idx].r;
            px.green = palette[idx].g;
            px.blue  = palette[idx].b;
            px.alpha = (idx == IDX_C3 && !four_colour) ? ALPHA_CLEAR : ALPHA_OPAQUE;
            px.pixel_number = PIXNUM_W'(i);
            px.last_pixel   = (px.pixel_number == PIX_LAST);
            owed_pixels = {owed_pixels, px};
        end
    endfunction

    function automatic void check_field(input string field, input logic [7:0] want, got);
        if (want !== got)
        begin
            $display("%0t: pixel %s mismatch, expected %h, actual %h", $time, field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want;
        if (!rst_n)
        begin
            owed_pixels.delete();
            pixels_owed <= 0;
        end
        else
        begin
            if (pixels.valid && pixels.ready)
            begin
                pixels_seen++;
                if (owed_pixels.size() == 0)
                begin
                    $display("%0t: pixel with none expected, actual %h %h %h %h #%0d last %b",
                             $time, pixels.red, pixels.green, pixels.blue, pixels.alpha,
                             pixels.pixel_number, pixels.last_pixel);
                    mismatches++;
                end
                else
                begin
                    want = owed_pixels.pop_front();
                    check_field("red", want.red, pixels.red);
                    check_field("green", want.green, pixels.green);
                    check_field("blue", want.blue, pixels.blue);
                    check_field("alpha", want.alpha, pixels.alpha);
                    check_field("pixel_number", 8'(want.pixel_number), 8'(pixels.pixel_number));
                    check_field("last_pixel", 8'(want.last_pixel), 8'(pixels.last_pixel));
                end
            end
            if (blocks.valid && blocks.ready)
                decode_block(blocks.endpoint_a, blocks.endpoint_b, blocks.selector_bits);
            pixels_owed <= owed_pixels.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives compressed colour blocks into the bc1 sub-block decoder and pulls
// its pixels with random gaps and stalls, including one long receiver hold.
// Checking is done by the pixel checker; this top gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int HOLD_CYCLES    = 120;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;

    logic        clk;
    logic        rst_n;
    int          src_idle_pct;
    int          sink_idle_pct;
    logic        pressure_req;
    logic        pressure_done;
    int unsigned blocks_sent;
    int unsigned four_colour_blocks;
    int unsigned mismatches;
    int unsigned pixels_owed;
    int unsigned pixels_seen;
    int unsigned quiet_cycles;

    bc1sd_block_if blk_if();
    bc1sd_pixel_if pix_if();

    bc1_subblock_decode_core dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .blocks (blk_if),
        .pixels (pix_if)
    );

    bc1sd_pixel_check pixel_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .blocks      (blk_if),
        .pixels      (pix_if),
        .mismatches  (mismatches),
        .pixels_owed (pixels_owed),
        .pixels_seen (pixels_seen)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic send_block(input logic [15:0] ea, eb, input logic [31:0] sel);
        while ($urandom_range(99) < src_idle_pct)
        begin
            blk_if.valid <= 1'b0;
            @(posedge clk);
        end
        blk_if.valid         <= 1'b1;
        blk_if.endpoint_a    <= ea;
        blk_if.endpoint_b    <= eb;
        blk_if.selector_bits <= sel;
        blocks_sent++;
        if (ea > eb)
            four_colour_blocks++;
        @(posedge clk);
        while (!blk_if.ready)
            @(posedge clk);
    endtask

    task automatic send_random(input int count);
        logic [15:0] ea;
        logic [15:0] eb;
        logic [31:0] sel;
        repeat (count)
        begin
            ea  = 16'($urandom);
            eb  = 16'($urandom);
            sel = $urandom;
            case ($urandom_range(7))
                0: eb = ea;
                1: eb = ea - 16'd1;
                2: ea = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                3: sel = {16{2'($urandom_range(3))}};
                default: ;
            endcase
            send_block(ea, eb, sel);
        end
    endtask

    // receiver: random stalls, plus one long hold when asked
    initial
    begin
        pix_if.ready  <= 1'b0;
        pressure_done <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (pressure_req && !pressure_done)
            begin
                pix_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                pressure_done <= 1'b1;
            end
            else
                pix_if.ready <= rst_n && ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (blk_if.valid && blk_if.ready) || (pix_if.valid && pix_if.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n                <= 1'b0;
        blk_if.valid         <= 1'b0;
        blk_if.endpoint_a    <= '0;
        blk_if.endpoint_b    <= '0;
        blk_if.selector_bits <= '0;
        pressure_req         <= 1'b0;
        src_idle_pct  = 16;
        sink_idle_pct = 50;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // equal endpoints fall into three-colour mode
        send_block(16'h0000, 16'h0000, 32'h0000_0000);
        send_block(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_block(16'h5A5A, 16'h5A5A, 32'hE4E4_E4E4);
        // four-colour mode, every index
        send_block(16'hFFFF, 16'h0000, 32'hE4E4_E4E4);
        send_block(16'h8000, 16'h7FFF, 32'h1B1B_1B1B);
        send_block(16'h1235, 16'h1234, 32'h5555_AAAA);
        // three-colour mode with the transparent entry
        send_block(16'h0000, 16'hFFFF, 32'h1B1B_1B1B);
        send_block(16'h1234, 16'h1235, 32'hFFFF_0000);
        send_block(16'h7FFF, 16'h8000, 32'h0000_FFFF);
        // single colour fields, red in the top bits, then one mixed pair
        send_block(16'hF800, 16'h07E0, 32'hE4E4_E4E4);
        send_block(16'h07E0, 16'hF800, 32'hE4E4_E4E4);
        send_block(16'h001F, 16'hF800, 32'hAAAA_AAAA);
        send_block(16'hF800, 16'h001F, 32'h3333_CCCC);
        send_block(16'hFFFE, 16'h0001, 32'h9C9C_6363);

        send_random(40);
        src_idle_pct  = 50;
        sink_idle_pct = 16;
        send_random(40);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        pressure_req <= 1'b1;
        send_random(40);
        blk_if.valid <= 1'b0;

        @(posedge clk);
        while (pixels_owed != 0 || !pressure_done)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d blocks (%0d four-colour, %0d three-colour), %0d pixels compared",
                 blocks_sent, four_colour_blocks, blocks_sent - four_colour_blocks, pixels_seen);
        $display("gaps on both sides, one %0d-cycle receiver hold with the input backed up",
                 HOLD_CYCLES);
        if (mismatches == 0 && pixels_owed == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/bc1sd_pkg.sv
hdl/bc1sd_if.sv
hdl/bc1sd_expand.sv
hdl/bc1sd_blend.sv
hdl/bc1sd_emit.sv
hdl/bc1_subblock_decode_core.sv
hdl/bc1sd_checker.sv
dv/bc1sd_pixel_check.sv
dv/testbench.sv
